[src/eicb_pkg.sv]
`timescale 1ns / 1ps
package eicb_pkg;

  localparam int DefStages = 24;
  localparam logic [15:0] TimeStepReset = 16'd1092;
  localparam logic signed [33:0] CordicStart = 34'sd652032874;
  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

  localparam logic [2:0] KIND_POS = 3'd0;
  localparam logic [2:0] KIND_ANG = 3'd1;
  localparam logic [2:0] KIND_FWD = 3'd2;
  localparam logic [2:0] KIND_UP = 3'd3;
  localparam logic [2:0] KIND_RIGHT = 3'd4;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0] pitch;
    logic [31:0] yaw;
    logic [31:0] roll;
    logic signed [31:0] pitch_rate;
    logic signed [31:0] yaw_rate;
    logic signed [31:0] roll_rate;
  } in_item_t;

  typedef struct packed {
    logic [2:0] vector_kind;
    logic signed [31:0] comp_x;
    logic signed [31:0] comp_y;
    logic signed [31:0] comp_z;
    logic last;
  } out_item_t;

  // one CORDIC lane traveling through the cell chain
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } rot_t;

  function automatic logic signed [33:0] arc_of(input int i);
    logic signed [33:0] r;
    begin
      case (i)
        0: r = 34'sd536870912;
        1: r = 34'sd316933406;
        2: r = 34'sd167458907;
        3: r = 34'sd85004756;
        4: r = 34'sd42667331;
        5: r = 34'sd21354465;
        6: r = 34'sd10679838;
        7: r = 34'sd5340245;
        8: r = 34'sd2670163;
        9: r = 34'sd1335087;
        10: r = 34'sd667544;
        11: r = 34'sd333772;
        12: r = 34'sd166886;
        13: r = 34'sd83443;
        14: r = 34'sd41722;
        15: r = 34'sd20861;
        16: r = 34'sd10430;
        17: r = 34'sd5215;
        18: r = 34'sd2608;
        19: r = 34'sd1304;
        20: r = 34'sd652;
        21: r = 34'sd326;
        22: r = 34'sd163;
        23: r = 34'sd81;
        24: r = 34'sd41;
        25: r = 34'sd20;
        26: r = 34'sd10;
        27: r = 34'sd5;
        28: r = 34'sd3;
        29: r = 34'sd1;
        30: r = 34'sd1;
        default: r = 34'sd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [33:0] clamp30(input logic signed [33:0] v);
    begin
      if (v > OneQ30) return OneQ30;
      if (v < -OneQ30) return -OneQ30;
      return v;
    end
  endfunction

endpackage

[src/euler_integrate_camera_basis.sv]
`timescale 1ns / 1ps
// A new item is accepted only while busy is low; each accepted start raises busy.
// The five result vectors of an item come out back to back and cannot be stalled.
// Sync active-low reset clears valid bits, the sequencer and time_step (1092).
// The sine/cosine chain is a row of CORDIC cells, one rotation per cell per cycle.
module euler_integrate_camera_basis import eicb_pkg::*; #(
  parameter int CORDIC_STAGES = DefStages
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  input  logic      cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic      out_strobe,
  output out_item_t out_item
);

  logic [15:0] time_step_r;
  always_ff @(posedge clk) begin
    if (!rst_n) time_step_r <= TimeStepReset;
    else if (cfg_we) time_step_r <= cfg_wdata;
  end

  // busy holds off new starts so that the result bursts of two items do not overlap
  logic [2:0] hold_r;
  logic acc;
  assign busy = (hold_r != 3'd0);
  assign acc = start && !busy;
  always_ff @(posedge clk) begin
    if (!rst_n) hold_r <= 3'd0;
    else if (acc) hold_r <= 3'd4;
    else if (busy) hold_r <= hold_r - 3'd1;
  end

  // stage A: step products (17x32 signed)
  function automatic logic signed [48:0] stp(input logic signed [31:0] v,
                                             input logic [15:0] dt);
    logic signed [49:0] p;
    begin
      p = $signed({{18{v[31]}}, v}) * $signed({34'd0, dt}) + 50'sd32768;
      return 49'(p >>> 16);
    end
  endfunction

  logic signed [33:0] sp_r [6];
  in_item_t ia_r;
  logic va_r;
  always_ff @(posedge clk) begin
    ia_r <= in_item;
    sp_r[0] <= 34'(stp(in_item.vel_x, time_step_r));
    sp_r[1] <= 34'(stp(in_item.vel_y, time_step_r));
    sp_r[2] <= 34'(stp(in_item.vel_z, time_step_r));
    sp_r[3] <= 34'(stp(in_item.pitch_rate, time_step_r));
    sp_r[4] <= 34'(stp(in_item.yaw_rate, time_step_r));
    sp_r[5] <= 34'(stp(in_item.roll_rate, time_step_r));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else va_r <= acc;
  end

  // stage B: sums, fold, CORDIC seed
  function automatic logic signed [31:0] sat(input logic signed [31:0] a,
                                             input logic signed [33:0] b);
    logic signed [34:0] s;
    begin
      s = 35'(a) + 35'(b);
      if (s > 35'sd2147483647) return 32'h7fffffff;
      if (s < -35'sd2147483648) return 32'h80000000;
      return s[31:0];
    end
  endfunction

  function automatic rot_t seed(input logic [31:0] ang, output logic flip);
    rot_t r;
    logic signed [33:0] z;
    begin
      z = 34'($signed(ang));
      flip = (z > OneQ30) || (z < -OneQ30);
      if (flip) z = 34'($signed(ang - 32'h80000000));
      r.x = CordicStart; r.y = '0; r.z = z;
      return r;
    end
  endfunction

  logic [31:0] ang_n [3];
  rot_t p0, y0;
  logic pf, yf;
  always_comb begin
    ang_n[0] = ia_r.pitch + sp_r[3][31:0];
    ang_n[1] = ia_r.yaw + sp_r[4][31:0];
    ang_n[2] = ia_r.roll + sp_r[5][31:0];
    p0 = seed(ang_n[0], pf);
    y0 = seed(ang_n[1], yf);
  end

  rot_t pc0_r, yc0_r;
  rot_t pc [CORDIC_STAGES+1];
  rot_t yc [CORDIC_STAGES+1];
  always_ff @(posedge clk) begin
    pc0_r <= p0;
    yc0_r <= y0;
  end
  assign pc[0] = pc0_r;
  assign yc[0] = yc0_r;

  genvar g;
  generate
    for (g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      eicb_cell #(.STAGE(g)) u_cell (
        .clk(clk), .pa_in(pc[g]), .ya_in(yc[g]),
        .pa_out(pc[g+1]), .ya_out(yc[g+1]));
    end
  endgenerate

  // side delay line for valid, flips, positions, angles
  typedef struct packed {
    logic v; logic pf; logic yf;
    logic [95:0] pos; logic [95:0] ang;
  } side_t;
  side_t sd_r [CORDIC_STAGES+1];
  always_ff @(posedge clk) begin
    if (!rst_n) sd_r[0] <= '0;
    else sd_r[0] <= '{v: va_r, pf: pf, yf: yf,
                      pos: {sat(ia_r.pos_x, sp_r[0]), sat(ia_r.pos_y, sp_r[1]),
                            sat(ia_r.pos_z, sp_r[2])},
                      ang: {ang_n[0], ang_n[1], ang_n[2]}};
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (!rst_n) sd_r[i+1] <= '0;
      else sd_r[i+1] <= sd_r[i];
    end
  end

  // stage C: flip/clamp, then products
  logic signed [33:0] sp_v, cp_v, sy_v, cy_v;
  always_comb begin
    side_t s;
    s = sd_r[CORDIC_STAGES];
    cp_v = clamp30(s.pf ? -pc[CORDIC_STAGES].x : pc[CORDIC_STAGES].x);
    sp_v = clamp30(s.pf ? -pc[CORDIC_STAGES].y : pc[CORDIC_STAGES].y);
    cy_v = clamp30(s.yf ? -yc[CORDIC_STAGES].x : yc[CORDIC_STAGES].x);
    sy_v = clamp30(s.yf ? -yc[CORDIC_STAGES].y : yc[CORDIC_STAGES].y);
  end

  function automatic logic signed [33:0] m30(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    logic signed [63:0] p;
    begin
      p = (64'(a) * 64'(b) + 64'sd536870912) >>> 30;
      return 34'(p);
    end
  endfunction

  logic signed [31:0] c_sp_r, c_rx_r, c_rz_r, c_fx_r, c_fz_r;
  side_t c_s_r;
  always_ff @(posedge clk) begin
    if (!rst_n) c_s_r <= '0;
    else c_s_r <= sd_r[CORDIC_STAGES];
    c_sp_r <= sp_v[31:0];
    c_rx_r <= (cp_v < 0) ? cy_v[31:0] : 32'(-cy_v);
    c_rz_r <= (cp_v < 0) ? 32'(-sy_v) : sy_v[31:0];
    c_fx_r <= 32'(clamp30(m30(cp_v[31:0], sy_v[31:0])));
    c_fz_r <= 32'(clamp30(m30(cp_v[31:0], cy_v[31:0])));
  end

  // stage D: up vector products
  logic signed [33:0] m1_r, m2_r, m3_r, m4_r;
  side_t d_s_r;
  logic signed [31:0] d_fx_r, d_fy_r, d_fz_r, d_rx_r, d_rz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) d_s_r <= '0;
    else d_s_r <= c_s_r;
    m1_r <= m30(c_rz_r, c_sp_r);
    m2_r <= m30(c_rz_r, c_fx_r);
    m3_r <= m30(c_rx_r, c_fz_r);
    m4_r <= m30(c_rx_r, c_sp_r);
    d_fx_r <= c_fx_r; d_fy_r <= c_sp_r; d_fz_r <= c_fz_r;
    d_rx_r <= c_rx_r; d_rz_r <= c_rz_r;
  end

  // output sequencer: steps through the five result vectors of each item
  logic [31:0] bx_r [5], by_r [5], bz_r [5];
  logic [2:0] k_r;
  logic run_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0; k_r <= KIND_POS;
    end else if (d_s_r.v) begin
      run_r <= 1'b1; k_r <= KIND_POS;
    end else if (run_r) begin
      if (k_r == KIND_RIGHT) run_r <= 1'b0;
      else k_r <= k_r + 3'd1;
    end
    if (d_s_r.v) begin
      bx_r[0] <= d_s_r.pos[95:64]; by_r[0] <= d_s_r.pos[63:32];
      bz_r[0] <= d_s_r.pos[31:0];
      bx_r[1] <= d_s_r.ang[95:64]; by_r[1] <= d_s_r.ang[63:32];
      bz_r[1] <= d_s_r.ang[31:0];
      bx_r[2] <= d_fx_r; by_r[2] <= d_fy_r; bz_r[2] <= d_fz_r;
      bx_r[3] <= 32'(clamp30(-m1_r));
      by_r[3] <= 32'(clamp30(m2_r - m3_r));
      bz_r[3] <= 32'(clamp30(m4_r));
      bx_r[4] <= d_rx_r; by_r[4] <= '0; bz_r[4] <= d_rz_r;
    end
  end

  assign out_strobe = run_r;
  always_comb begin
    out_item.vector_kind = k_r;
    out_item.comp_x = bx_r[k_r];
    out_item.comp_y = by_r[k_r];
    out_item.comp_z = bz_r[k_r];
    out_item.last = (k_r == KIND_RIGHT);
  end

`ifndef ASSERT_OFF
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> busy) else $error("busy not raised after start");
  a_last_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.last |-> out_item.vector_kind == KIND_RIGHT)
    else $error("last on wrong kind");
  a_kind_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |=> out_strobe)
    else $error("result burst broken");
`endif

endmodule

[src/eicb_cell.sv]
`timescale 1ns / 1ps
module eicb_cell import eicb_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic clk,
  input  rot_t pa_in,
  input  rot_t ya_in,
  output rot_t pa_out,
  output rot_t ya_out
);

  localparam logic signed [33:0] Arc = arc_of(STAGE);

  function automatic rot_t rot(input rot_t v);
    rot_t r;
    logic signed [33:0] dx, dy;
    begin
      dx = v.y >>> STAGE;
      dy = v.x >>> STAGE;
      if (!v.z[33]) begin
        r.x = v.x - dx; r.y = v.y + dy; r.z = v.z - Arc;
      end else begin
        r.x = v.x + dx; r.y = v.y - dy; r.z = v.z + Arc;
      end
      return r;
    end
  endfunction

  rot_t pa_r, ya_r;
  always_ff @(posedge clk) begin
    pa_r <= rot(pa_in);
    ya_r <= rot(ya_in);
  end
  assign pa_out = pa_r;
  assign ya_out = ya_r;

endmodule
